FILE: hw/rtl/vgm_pkg.sv
// ----------------------------------------------------------------------------
// vgm_pkg
// Shared widths, codes and transfer structs of the voxel gradient block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vgm_pkg;

  localparam int OP_W      = 1;
  localparam int VOX_W     = 8;
  localparam int GRAD_W    = 8;
  localparam int IDX_W     = 24;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CLAMP_W   = 11;

  localparam logic [OP_W-1:0]    OP_VOXEL  = 1'b0;
  localparam logic [CFG_W-1:0]   DIM_RESET = 9'd256;
  localparam logic [CLAMP_W-1:0] DIM_MIN   = 11'd3;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH  = 2'd0,
    REG_ROW_COUNT   = 2'd1,
    REG_PLANE_COUNT = 2'd2
  } cfg_reg_t;

  // control of one accepted transaction, from the sequencer to the datapath
  typedef struct packed {
    logic             valid;
    logic             step;
    logic             emit;
    logic             interior;
    logic             last;
    logic [IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [GRAD_W-1:0] gradient;
    logic [IDX_W-1:0]  index;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vgm_if.sv
// ----------------------------------------------------------------------------
// vgm_if
// Valid/ready channels of the voxel gradient block: voxel input, result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vgm_in_if import vgm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [VOX_W-1:0] voxel;

  modport source (output valid, output op, output voxel, input ready);
  modport sink   (input valid, input op, input voxel, output ready);
endinterface

interface vgm_out_if import vgm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GRAD_W-1:0] gradient;
  logic [IDX_W-1:0]  voxel_index;
  logic              last_in_volume;

  modport source (output valid, output gradient, output voxel_index,
                  output last_in_volume, input ready);
  modport sink   (input valid, input gradient, input voxel_index,
                  input last_in_volume, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/vgm_ctrl.sv
// ----------------------------------------------------------------------------
// vgm_ctrl
// Configuration registers, volume position counters and store addressing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgm_ctrl import vgm_pkg::*; #(
  parameter int MAX_ROW_LENGTH  = 256,
  parameter int MAX_ROW_COUNT   = 256,
  parameter int MAX_PLANE_COUNT = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 acc,
  input  wire logic [OP_W-1:0]      op,
  output req_t                      req,
  output logic [$clog2(MAX_ROW_LENGTH*MAX_ROW_COUNT)-1:0] addr_a,
  output logic [$clog2(MAX_ROW_LENGTH*MAX_ROW_COUNT)-1:0] addr_b,
  output logic [$clog2(MAX_ROW_LENGTH)-1:0]               addr_row
);

  localparam int LW = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CW = $clog2(MAX_ROW_COUNT + 1);
  localparam int NW = $clog2(MAX_PLANE_COUNT + 1);
  localparam int XW = $clog2(MAX_ROW_LENGTH);
  localparam int YW = $clog2(MAX_ROW_COUNT);
  localparam int ZW = $clog2(MAX_PLANE_COUNT);
  localparam int PW = $clog2(MAX_ROW_LENGTH * MAX_ROW_COUNT);

  function automatic logic [CLAMP_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CLAMP_W-1:0] hi);
    logic [CLAMP_W-1:0] w;
    w = CLAMP_W'(v);
    if (w < DIM_MIN) begin
      w = DIM_MIN;
    end
    if (w > hi) begin
      w = hi;
    end
    return w;
  endfunction

  localparam logic [CLAMP_W-1:0] HI_RL = CLAMP_W'(MAX_ROW_LENGTH);
  localparam logic [CLAMP_W-1:0] HI_RC = CLAMP_W'(MAX_ROW_COUNT);
  localparam logic [CLAMP_W-1:0] HI_PC = CLAMP_W'(MAX_PLANE_COUNT);

  logic [LW-1:0]    rl_r, rl_nxt;
  logic [CW-1:0]    rc_r, rc_nxt;
  logic [NW-1:0]    pc_r, pc_nxt;
  logic [XW-1:0]    x_r, x_nxt;
  logic [YW-1:0]    y_r, y_nxt;
  logic [ZW-1:0]    z_r, z_nxt;
  logic [PW-1:0]    p_r, p_nxt;
  logic [IDX_W-1:0] q_r, q_nxt;
  logic             done_r, done_nxt;

  logic x_last, y_last, z_last, is_voxel, step, emit;

  assign x_last   = LW'(x_r) == (rl_r - LW'(1));
  assign y_last   = CW'(y_r) == (rc_r - CW'(1));
  assign z_last   = NW'(z_r) == (pc_r - NW'(1));
  assign is_voxel = op == OP_VOXEL;
  assign step     = acc && !done_r && is_voxel;
  // once the volume is fed any transaction drains one pending result
  assign emit     = acc && (done_r || (is_voxel && (z_r != '0)));

  always_comb begin
    rl_nxt   = rl_r;
    rc_nxt   = rc_r;
    pc_nxt   = pc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    p_nxt    = p_r;
    q_nxt    = q_r;
    done_nxt = done_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ROW_LENGTH:  rl_nxt = LW'(clamp_dim(cfg_data, HI_RL));
        REG_ROW_COUNT:   rc_nxt = CW'(clamp_dim(cfg_data, HI_RC));
        REG_PLANE_COUNT: pc_nxt = NW'(clamp_dim(cfg_data, HI_PC));
        default: ;
      endcase
      if (cfg_index == REG_ROW_LENGTH || cfg_index == REG_ROW_COUNT ||
          cfg_index == REG_PLANE_COUNT) begin
        x_nxt    = '0;
        y_nxt    = '0;
        z_nxt    = '0;
        p_nxt    = '0;
        q_nxt    = '0;
        done_nxt = 1'b0;
      end
    end else if (acc && done_r) begin
      // drain the last plane, reusing x and y as its position
      q_nxt = q_r + IDX_W'(1);
      if (x_last) begin
        x_nxt = '0;
        if (y_last) begin
          y_nxt    = '0;
          z_nxt    = '0;
          p_nxt    = '0;
          q_nxt    = '0;
          done_nxt = 1'b0;
        end else begin
          y_nxt = y_r + YW'(1);
        end
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end else if (step) begin
      if (emit) begin
        q_nxt = q_r + IDX_W'(1);
      end
      p_nxt = p_r + PW'(1);
      if (x_last) begin
        x_nxt = '0;
        if (y_last) begin
          y_nxt = '0;
          p_nxt = '0;
          if (z_last) begin
            z_nxt    = '0;
            done_nxt = 1'b1;
          end else begin
            z_nxt = z_r + ZW'(1);
          end
        end else begin
          y_nxt = y_r + YW'(1);
        end
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rl_r   <= LW'(clamp_dim(DIM_RESET, HI_RL));
      rc_r   <= CW'(clamp_dim(DIM_RESET, HI_RC));
      pc_r   <= NW'(clamp_dim(DIM_RESET, HI_PC));
      x_r    <= '0;
      y_r    <= '0;
      z_r    <= '0;
      p_r    <= '0;
      q_r    <= '0;
      done_r <= 1'b0;
    end else begin
      rl_r   <= rl_nxt;
      rc_r   <= rc_nxt;
      pc_r   <= pc_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      p_r    <= p_nxt;
      q_r    <= q_nxt;
      done_r <= done_nxt;
    end
  end

  always_comb begin
    req.valid    = acc;
    req.step     = step;
    req.emit     = emit;
    req.interior = (x_r != '0) && !x_last && (y_r != '0) && !y_last &&
                   (z_r > ZW'(1)) && !done_r;
    req.last     = done_r && x_last && y_last;
    req.index    = q_r;
  end

  // the column one row and one voxel ahead still holds the previous plane
  assign addr_a   = p_r;
  assign addr_b   = p_r + PW'(rl_r) + PW'(1);
  assign addr_row = x_r;

endmodule

`default_nettype wire

FILE: hw/rtl/vgm_store.sv
// ----------------------------------------------------------------------------
// vgm_store
// Column and row-delay memories, neighbor alignment and gradient arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgm_store import vgm_pkg::*; #(
  parameter int MAX_ROW_LENGTH = 256,
  parameter int MAX_ROW_COUNT  = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire req_t                 req,
  input  wire logic [$clog2(MAX_ROW_LENGTH*MAX_ROW_COUNT)-1:0] addr_a,
  input  wire logic [$clog2(MAX_ROW_LENGTH*MAX_ROW_COUNT)-1:0] addr_b,
  input  wire logic [$clog2(MAX_ROW_LENGTH)-1:0]               addr_row,
  input  wire logic [VOX_W-1:0]     voxel,
  output logic                      busy,
  output logic                      res_valid,
  output res_t                      res
);

  localparam int PW    = $clog2(MAX_ROW_LENGTH * MAX_ROW_COUNT);
  localparam int XW    = $clog2(MAX_ROW_LENGTH);
  localparam int DEPTH = MAX_ROW_LENGTH * MAX_ROW_COUNT;
  localparam int WW    = 2 * VOX_W;

  function automatic logic [VOX_W-2:0] half_diff(input logic [VOX_W-1:0] a,
                                                 input logic [VOX_W-1:0] b);
    logic [VOX_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d[VOX_W-1:1];
  endfunction

  // column word: {voxel of the newer plane, voxel of the older plane}
  logic [WW-1:0] col_mem [0:DEPTH-1];
  // row delay word: {center column voxel, column voxel one row ahead}
  logic [WW-1:0] row_mem [0:MAX_ROW_LENGTH-1];

  logic [WW-1:0]    col_a_r, col_b_r, row_r;
  logic             s1_valid_r;
  req_t             s1_req_r;
  logic [VOX_W-1:0] s1_vox_r;
  logic [PW-1:0]    s1_addr_r;
  logic [XW-1:0]    s1_row_r;
  logic [VOX_W-1:0] prev_c_r, prev_s_r;

  logic [VOX_W-1:0] c_cur, c_ahead, c_xm, c_xp, c_ym, c_yp, c_zm, c_zp;
  logic [VOX_W-2:0] hx, hy, hz;
  logic [VOX_W:0]   sum;
  logic [GRAD_W-1:0] sat;

  always_ff @(posedge clk) begin
    if (req.valid && req.step) begin
      col_a_r <= col_mem[addr_a];
      col_b_r <= col_mem[addr_b];
      row_r   <= row_mem[addr_row];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_req_r.step) begin
      col_mem[s1_addr_r] <= {s1_vox_r, c_cur};
      row_mem[s1_row_r]  <= {c_cur, c_ahead};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r  <= req;
    s1_vox_r  <= voxel;
    s1_addr_r <= addr_a;
    s1_row_r  <= addr_row;
    if (s1_valid_r && s1_req_r.step) begin
      prev_c_r <= c_cur;
      prev_s_r <= c_ahead;
    end
  end

  assign c_cur   = col_a_r[WW-1:VOX_W];
  assign c_ahead = col_b_r[WW-1:VOX_W];
  assign c_xm    = prev_c_r;
  assign c_xp    = row_r[VOX_W-1:0];
  assign c_ym    = row_r[WW-1:VOX_W];
  assign c_yp    = prev_s_r;
  assign c_zm    = col_a_r[VOX_W-1:0];
  assign c_zp    = s1_vox_r;

  always_comb begin
    hx  = half_diff(c_xm, c_xp);
    hy  = half_diff(c_ym, c_yp);
    hz  = half_diff(c_zm, c_zp);
    sum = (VOX_W+1)'(hx) + (VOX_W+1)'(hy) + (VOX_W+1)'(hz);
    sat = sum[VOX_W] ? '1 : GRAD_W'(sum);
  end

  assign busy         = s1_valid_r;
  assign res_valid    = s1_valid_r && s1_req_r.emit;
  assign res.gradient = s1_req_r.interior ? sat : '0;
  assign res.index    = s1_req_r.index;
  assign res.last     = s1_req_r.last;

endmodule

`default_nettype wire

FILE: hw/rtl/vgm_outq.sv
// ----------------------------------------------------------------------------
// vgm_outq
// Small result queue that decouples the pipeline from a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgm_outq import vgm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire res_t               push_data,
  input  wire logic               pop_ready,
  output logic                    pop_valid,
  output res_t                    pop_data,
  output logic [OUTQ_CW-1:0]      count
);

  res_t                 q_mem [0:OUTQ_DEPTH-1];
  logic [OUTQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                 pop;

  assign pop_valid = cnt_r != '0;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = q_mem[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + OUTQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + OUTQ_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + OUTQ_CW'(push) - OUTQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/voxel_gradient_magnitude_3d.sv
// ----------------------------------------------------------------------------
// voxel_gradient_magnitude_3d
// L1 central-difference gradient magnitude over a streamed 3-D volume.
// ----------------------------------------------------------------------------
// Voxels enter on in_ch (op voxel or flush) in memory order: row position
// fastest, then row, then plane. Each result on out_ch carries the gradient,
// the linear voxel index and a last-in-volume flag. Results trail the input
// by one plane; after the final voxel one flush (or any item) per result
// drains the last plane, whose results are all zero.
// Throughput is one transaction per cycle while in_ch.ready is high: each
// voxel costs one read-modify-write of the column memory (two reads, one
// write) and one read and one write of the row-delay memory. A result is
// held in the s1 stage registers and then pushed into the result queue.
// When out_ch stalls, a four-entry result queue absorbs what is in flight
// and in_ch.ready drops once the queue would otherwise overflow.
// Reset clears counters and sets all dimensions to 256 (clamped to the
// maximum parameters); memory contents are not cleared and need no pass.
// A write to one of the three configuration registers restarts the volume.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_gradient_magnitude_3d import vgm_pkg::*; #(
  parameter int MAX_ROW_LENGTH  = 256,
  parameter int MAX_ROW_COUNT   = 256,
  parameter int MAX_PLANE_COUNT = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  vgm_in_if.sink                    in_ch,
  vgm_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int PW = $clog2(MAX_ROW_LENGTH * MAX_ROW_COUNT);
  localparam int XW = $clog2(MAX_ROW_LENGTH);

  req_t               req;
  logic [PW-1:0]      addr_a, addr_b;
  logic [XW-1:0]      addr_row;
  logic               busy, res_valid, acc, in_rdy;
  res_t               res, out_data;
  logic [OUTQ_CW-1:0] q_count;

  // room for the queued results, the one in flight and the new one
  assign in_rdy      = (q_count + OUTQ_CW'(busy)) < OUTQ_CW'(OUTQ_DEPTH);
  assign in_ch.ready = in_rdy;
  assign acc         = in_ch.valid && in_rdy;

  vgm_ctrl #(
    .MAX_ROW_LENGTH  (MAX_ROW_LENGTH),
    .MAX_ROW_COUNT   (MAX_ROW_COUNT),
    .MAX_PLANE_COUNT (MAX_PLANE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .op        (in_ch.op),
    .req       (req),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .addr_row  (addr_row)
  );

  vgm_store #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .MAX_ROW_COUNT  (MAX_ROW_COUNT)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .addr_row  (addr_row),
    .voxel     (in_ch.voxel),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  vgm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop_ready (out_ch.ready),
    .pop_valid (out_ch.valid),
    .pop_data  (out_data),
    .count     (q_count)
  );

  assign out_ch.gradient       = out_data.gradient;
  assign out_ch.voxel_index    = out_data.index;
  assign out_ch.last_in_volume = out_data.last;

endmodule

`default_nettype wire
